@@ sv/resource_context_table_core_defines.svh @@
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef RESOURCE_CONTEXT_TABLE_CORE_DEFINES_SVH
`define RESOURCE_CONTEXT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define RCT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rct assertion failed");

// Next-cycle implication.
`define RCT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rct assertion failed");

`endif

@@ sv/rct_pkg.sv @@
`default_nettype none

package rct_pkg;

    // fixed payload widths
    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int CTX_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // default geometry
    localparam int NUM_ENTRIES = 256;
    localparam int NUM_SLOTS   = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_SAVE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_CTX   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [KEY_W-1:0]  resource_id;
        logic [CTX_W-1:0]  context_index;
        logic [DATA_W-1:0] data_word;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_data;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_FREAD,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

@@ sv/rct_ram.sv @@
`default_nettype none

// simple dual-port RAM, one write, one registered read
module rct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/resource_context_table_core.sv @@
`default_nettype none

// channel | direction | handshake            | beat
// --------+-----------+----------------------+--------------------------------
// req     | in        | req_valid, req_stall | operation, id, context, data
// rsp     | out       | rsp_valid, rsp_stall | status, read_data
//
// One beat at a time. From accept to the next accept the block runs a key scan
// over the used entries, execute, a data read on a find that hits a live slot,
// response load and idle. Bad context, zero id and unknown operation skip the
// scan. req_stall is high unless idle. A stalled rsp beat holds in the output
// register while the next request runs; that result then waits in res_reg.
// Reset clears the state, the fill count and the compare and response valids.
module resource_context_table_core #(
    parameter int NUM_ENTRIES = rct_pkg::NUM_ENTRIES,
    parameter int NUM_SLOTS   = rct_pkg::NUM_SLOTS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire rct_pkg::req_t req,

    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output rct_pkg::rsp_t      rsp
);

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int DA_W   = $clog2(NUM_ENTRIES * NUM_SLOTS);
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ROW_W  = rct_pkg::KEY_W + NUM_SLOTS;
    localparam int LIM_W  = rct_pkg::CTX_W + 1;

    localparam logic [LIM_W-1:0] SLOT_LIM = LIM_W'(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    // request registers
    rct_pkg::state_t             state_reg, state_next;
    logic [rct_pkg::OP_W-1:0]    op_reg, op_next;
    logic [rct_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [rct_pkg::DATA_W-1:0]  data_reg, data_next;

    // table fill count: entries below it are searched
    logic [IDX_W-1:0]            used_reg, used_next;

    // scan pipeline
    logic [IDX_W-1:0]            issue_idx_reg, issue_idx_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                        hit_reg, hit_next;
    logic [IDX_W-1:0]            hit_idx_reg, hit_idx_next;
    logic [NUM_SLOTS-1:0]        hit_mask_reg, hit_mask_next;
    logic                        free_reg, free_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;

    // result holding and response registers
    rct_pkg::rsp_t               res_reg, res_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    rct_pkg::rsp_t               rsp_reg, rsp_next;

    // RAM ports
    logic                        row_we;
    logic [ROW_W-1:0]            row_wdata;
    logic                        row_re;
    logic [ROW_W-1:0]            row_rdata;
    logic                        dat_we;
    logic                        dat_re;
    logic [DA_W-1:0]             dat_addr;
    logic [rct_pkg::DATA_W-1:0]  dat_rdata;

    // decode
    logic                        accept;
    logic                        pre_bad_ctx;
    logic                        pre_not_found;
    logic                        issue_more;
    logic                        scan_done;
    logic [rct_pkg::KEY_W-1:0]   row_key;
    logic [NUM_SLOTS-1:0]        row_mask;
    logic [NUM_SLOTS-1:0]        slot_bit;
    logic                        new_entry;
    logic                        overflow;
    logic [IDX_W-1:0]            tgt_idx;
    logic [NUM_SLOTS-1:0]        base_mask;
    logic [NUM_SLOTS-1:0]        del_mask;
    logic                        slot_live;
    logic                        rsp_free;

    assign accept        = req_valid && !req_stall;
    assign pre_bad_ctx   = {1'b0, req.context_index} >= SLOT_LIM;
    assign pre_not_found = (req.resource_id == '0) ||
                           ((req.operation != rct_pkg::OP_SAVE) &&
                            (req.operation != rct_pkg::OP_DELETE) &&
                            (req.operation != rct_pkg::OP_FIND));

    assign issue_more = issue_idx_reg < used_reg;
    assign scan_done  = !issue_more && !cmp_vld_reg;

    assign row_key  = row_rdata[ROW_W-1 -: rct_pkg::KEY_W];
    assign row_mask = row_rdata[NUM_SLOTS-1:0];
    assign slot_bit = NUM_SLOTS'(1) << slot_reg;

    // target entry of a save: hit, else first freed, else next new
    assign new_entry = !hit_reg && !free_reg;
    assign overflow  = new_entry && (used_reg == LAST_IDX);
    assign tgt_idx   = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : used_reg);
    assign base_mask = hit_reg ? hit_mask_reg : '0;
    assign del_mask  = hit_mask_reg & ~slot_bit;
    assign slot_live = (hit_mask_reg & slot_bit) != '0;
    assign dat_addr  = DA_W'(tgt_idx) * DA_W'(NUM_SLOTS) + DA_W'(slot_reg);

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // key + slot-valid row per entry
    rct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ENTRIES)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (tgt_idx),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (issue_idx_reg),
        .rdata (row_rdata)
    );

    // slot data words
    rct_ram #(
        .WIDTH (rct_pkg::DATA_W),
        .DEPTH (NUM_ENTRIES * NUM_SLOTS)
    ) u_dat_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_addr),
        .wdata (data_reg),
        .re    (dat_re),
        .raddr (dat_addr),
        .rdata (dat_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (pre_bad_ctx || pre_not_found) ? rct_pkg::S_RESP
                                                                : rct_pkg::S_SCAN;
                end
            end
            rct_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = rct_pkg::S_EXEC;
                end
            end
            rct_pkg::S_EXEC:
            begin
                if ((op_reg == rct_pkg::OP_FIND) && hit_reg && slot_live)
                begin
                    state_next = rct_pkg::S_FREAD;
                end
                else
                begin
                    state_next = rct_pkg::S_RESP;
                end
            end
            rct_pkg::S_FREAD:
            begin
                state_next = rct_pkg::S_RESP;
            end
            rct_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = rct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rct_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        slot_next      = slot_reg;
        data_next      = data_reg;
        used_next      = used_reg;
        issue_idx_next = issue_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = issue_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_mask_next  = hit_mask_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        row_we         = 1'b0;
        row_wdata      = {key_reg, base_mask | slot_bit};
        row_re         = 1'b0;
        dat_we         = 1'b0;
        dat_re         = 1'b0;

        case (state_reg)
            rct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.operation;
                    key_next       = req.resource_id;
                    slot_next      = req.context_index[SLOT_W-1:0];
                    data_next      = req.data_word;
                    issue_idx_next = '0;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    res_next.read_data = '0;
                    res_next.status    = pre_bad_ctx ? rct_pkg::STAT_BAD_CTX
                                                     : rct_pkg::STAT_NOT_FOUND;
                end
            end
            rct_pkg::S_SCAN:
            begin
                // issue one row read per cycle, compare in the cycle after
                if (issue_more)
                begin
                    row_re         = 1'b1;
                    cmp_vld_next   = 1'b1;
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (row_key == key_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                        hit_mask_next = row_mask;
                    end
                    if ((row_key == '0) && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
            end
            rct_pkg::S_EXEC:
            begin
                res_next.read_data = '0;
                case (op_reg)
                    rct_pkg::OP_SAVE:
                    begin
                        row_we    = 1'b1;
                        row_wdata = {key_reg, base_mask | slot_bit};
                        dat_we    = 1'b1;
                        if (new_entry && !overflow)
                        begin
                            used_next = used_reg + IDX_W'(1);
                        end
                        res_next.status = overflow ? rct_pkg::STAT_OVERFLOW
                                                   : rct_pkg::STAT_OK;
                    end
                    rct_pkg::OP_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            // entry is freed once its last slot goes
                            row_we    = 1'b1;
                            row_wdata = {(del_mask == '0) ? {rct_pkg::KEY_W{1'b0}} : key_reg,
                                         del_mask};
                            res_next.status = rct_pkg::STAT_OK;
                        end
                        else
                        begin
                            res_next.status = rct_pkg::STAT_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        dat_re          = hit_reg && slot_live;
                        res_next.status = rct_pkg::STAT_NOT_FOUND;
                    end
                endcase
            end
            rct_pkg::S_FREAD:
            begin
                if (dat_rdata != '0)
                begin
                    res_next.status    = rct_pkg::STAT_OK;
                    res_next.read_data = dat_rdata;
                end
                else
                begin
                    res_next.status = rct_pkg::STAT_NOT_FOUND;
                end
            end
            rct_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
                cmp_vld_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rct_pkg::S_IDLE;
            used_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_vld_reg   <= cmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        slot_reg      <= slot_next;
        data_reg      <= data_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_mask_reg  <= hit_mask_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    assign req_stall = (state_reg != rct_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ sv/rct_checker.sv @@
`default_nettype none

`include "resource_context_table_core_defines.svh"

// port-level checks for resource_context_table_core
module rct_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire rct_pkg::rsp_t rsp
);

    logic req_beat;

    assign req_beat = req_valid && !req_stall;

    // a stalled response beat holds
    `RCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // only a good find carries data
    `RCT_ASSERT_NOW(a_data_only_ok, rsp_valid && (rsp.status != rct_pkg::STAT_OK), rsp.read_data == '0)

    // one request in flight: busy right after a request beat
    `RCT_ASSERT_NEXT(a_busy_after_req, req_beat, req_stall)

    // a new request beat never coincides with its own response
    `RCT_ASSERT_NEXT(a_no_same_cycle_rsp, req_beat && !rsp_valid, !rsp_valid)

endmodule

bind resource_context_table_core rct_checker u_rct_checker (.*);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import rct_pkg::*;

    // op code 3 is not defined in the package; the block must reject it
    localparam logic [OP_W-1:0] OP_ILLEGAL = 2'd3;

    localparam int LONG_HOLD   = 600;        // receiver hold-off, in cycles
    localparam int DRAIN_WAIT  = NUM_ENTRIES + 16;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;

    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    resource_context_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table. Only entries below live_entries (and the
    // overflow entry) ever get a key written, so bit types are fine here.
    // ------------------------------------------------------------------
    bit [KEY_W-1:0]  id_table  [NUM_ENTRIES];
    bit [DATA_W-1:0] slot_word [NUM_ENTRIES * NUM_SLOTS];
    bit              slot_live [NUM_ENTRIES * NUM_SLOTS];
    int              live_entries = 0;

    // Applies one request beat to the shadow table, returns the response.
    function automatic rsp_t table_access(req_t b);
        rsp_t res;
        int   hit;
        int   e;
        bit   seen_free;
        bit   any_live;
        res.status    = STAT_OK;
        res.read_data = '0;
        hit           = -1;
        seen_free     = 1'b0;
        any_live      = 1'b0;
        if (b.context_index >= NUM_SLOTS)
        begin
            // bad context wins over everything, no side effect
            res.status = STAT_BAD_CTX;
        end
        else if (b.resource_id == '0 || b.operation == OP_ILLEGAL)
        begin
            res.status = STAT_NOT_FOUND;
        end
        else
        begin
            // linear search over the used entries only
            for (int i = 0; i < live_entries; i++)
                if (hit < 0 && id_table[i] == b.resource_id)
                    hit = i;
            case (b.operation)
                OP_SAVE:
                begin
                    e = hit;
                    if (hit < 0)
                    begin
                        // first freed entry, else next unused one
                        e = live_entries;
                        for (int i = 0; i < live_entries; i++)
                            if (!seen_free && id_table[i] == '0)
                            begin
                                e         = i;
                                seen_free = 1'b1;
                            end
                        if (e >= NUM_ENTRIES - 1)
                        begin
                            // last entry is a scratch entry, never counted
                            e          = NUM_ENTRIES - 1;
                            res.status = STAT_OVERFLOW;
                        end
                        else if (e == live_entries)
                        begin
                            live_entries++;
                        end
                        id_table[e] = b.resource_id;
                    end
                    slot_word[e * NUM_SLOTS + b.context_index] = b.data_word;
                    slot_live[e * NUM_SLOTS + b.context_index] = 1'b1;
                end
                OP_DELETE:
                begin
                    if (hit < 0)
                    begin
                        res.status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        slot_live[hit * NUM_SLOTS + b.context_index] = 1'b0;
                        for (int s = 0; s < NUM_SLOTS; s++)
                            if (slot_live[hit * NUM_SLOTS + s])
                                any_live = 1'b1;
                        // free the entry once its last slot is gone
                        if (!any_live)
                            id_table[hit] = '0;
                    end
                end
                default:
                begin
                    // find: empty slot or zero data reads as not found
                    if (hit < 0)
                        res.status = STAT_NOT_FOUND;
                    else if (slot_live[hit * NUM_SLOTS + b.context_index] &&
                             slot_word[hit * NUM_SLOTS + b.context_index] != '0)
                        res.read_data = slot_word[hit * NUM_SLOTS + b.context_index];
                    else
                        res.status = STAT_NOT_FOUND;
                end
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Queues and shared counters
    // ------------------------------------------------------------------
    req_t            pending_beats [$];   // request beats not yet driven
    rsp_t            awaited_rsp   [$];   // predicted responses, in order
    logic [KEY_W-1:0] id_pool      [$];   // ids that random traffic targets
    logic [KEY_W-1:0] fill_ids     [$];   // ids stored while filling up
    logic [CTX_W-1:0] fill_ctx     [$];   // the one slot each of them used

    int beats_accepted = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 16;
    int recv_idle_pct  = 49;
    int hold_trigger   = 0;   // bumped to ask the receiver for a long hold
    int hold_seen;
    int hold_left;

    // ------------------------------------------------------------------
    // Request driver: a new beat may be loaded only when the current one
    // was taken or nothing is on offer. Prediction happens at acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                awaited_rsp.push_back(table_access(req));
                beats_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req       <= pending_beats.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side stall: random, or a long hold-off on request so the
    // block backs up into its input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen <= hold_trigger;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: each taken beat against the oldest prediction.
    // ------------------------------------------------------------------
    rsp_t want;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $error("response beat with nothing expected: status %0d read_data %h",
                       rsp.status, rsp.read_data);
                error_count++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
                    error_count++;
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d responses outstanding",
                   cycle_count, awaited_rsp.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] id,
                              logic [CTX_W-1:0] ctx, logic [DATA_W-1:0] data);
        req_t b;
        b.operation     = op;
        b.resource_id   = id;
        b.context_index = ctx;
        b.data_word     = data;
        pending_beats.push_back(b);
    endtask

    function automatic logic [KEY_W-1:0] fresh_id();
        logic [KEY_W-1:0] k;
        k = $urandom;
        if (k == '0)
            k = 'd1;
        return k;
    endfunction

    // Mostly well-formed ops on pool ids; a few malformed beats mixed in.
    task automatic push_traffic(int count);
        req_t b;
        int   pick;
        for (int n = 0; n < count; n++)
        begin
            pick            = $urandom_range(99);
            b.resource_id   = id_pool[$urandom_range(id_pool.size() - 1)];
            b.context_index = CTX_W'($urandom_range(NUM_SLOTS - 1));
            b.data_word     = ($urandom_range(9) == 0) ? '0 : DATA_W'($urandom);
            if (pick < 45)
                b.operation = OP_SAVE;
            else if (pick < 78)
                b.operation = OP_FIND;
            else if (pick < 92)
                b.operation = OP_DELETE;
            else
            begin
                b.operation = OP_W'($urandom_range(3));
                case ($urandom_range(3))
                    0: b.context_index = CTX_W'($urandom_range(7, NUM_SLOTS));
                    1: b.resource_id   = '0;
                    2: b.operation     = OP_ILLEGAL;
                    default:
                    begin
                        // unknown id: only delete/find, a save would allocate
                        b.resource_id = fresh_id();
                        b.operation   = $urandom_range(1) ? OP_FIND : OP_DELETE;
                    end
                endcase
            end
            pending_beats.push_back(b);
        end
    endtask

    // Allocate a new id, touch a few slots, then clear every slot so the
    // entry is freed and can be reused by a later save.
    task automatic push_churn();
        logic [KEY_W-1:0] k;
        logic [CTX_W-1:0] c;
        int               used;
        k    = fresh_id();
        used = $urandom_range(3, 1);
        for (int n = 0; n < used; n++)
        begin
            c = CTX_W'($urandom_range(NUM_SLOTS - 1));
            queue_beat(OP_SAVE, k, c, $urandom);
            queue_beat(OP_FIND, k, c, $urandom);
        end
        for (int s = 0; s < NUM_SLOTS; s++)
            queue_beat(OP_DELETE, k, CTX_W'(s), $urandom);
        queue_beat(OP_FIND, k, CTX_W'($urandom_range(NUM_SLOTS - 1)), $urandom);
    endtask

    // Sender pause: nothing new is offered until every response is back.
    // Checked at the falling edge, once the rising-edge updates have settled.
    task automatic wait_drained();
        while (pending_beats.size() != 0 || req_valid || awaited_rsp.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [KEY_W-1:0] k;
        int               j;
        int               c_base;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, id/data extremes, bad context on every op,
        // zero id, illegal op, zero data, empty slot, freeing and reuse
        queue_beat(OP_FIND,    32'h0000_0001, 3'd0, 32'h0);
        queue_beat(OP_DELETE,  32'h0000_0001, 3'd0, 32'h0);
        queue_beat(OP_SAVE,    32'h0000_0001, 3'd0, 32'hFFFF_FFFF);
        queue_beat(OP_SAVE,    32'hFFFF_FFFF, 3'd4, 32'h0);
        queue_beat(OP_SAVE,    32'h0000_0001, 3'd4, 32'h0000_0001);
        queue_beat(OP_FIND,    32'h0000_0001, 3'd0, 32'h0);
        queue_beat(OP_FIND,    32'hFFFF_FFFF, 3'd4, 32'h0);
        queue_beat(OP_FIND,    32'h0000_0001, 3'd3, 32'h0);
        queue_beat(OP_SAVE,    32'h0000_0001, 3'd5, 32'h1234_5678);
        queue_beat(OP_FIND,    32'h0000_0001, 3'd7, 32'h0);
        queue_beat(OP_DELETE,  32'hFFFF_FFFF, 3'd6, 32'h0);
        queue_beat(OP_SAVE,    32'h0000_0000, 3'd0, 32'hDEAD_BEEF);
        queue_beat(OP_FIND,    32'h0000_0000, 3'd0, 32'h0);
        queue_beat(OP_DELETE,  32'h0000_0000, 3'd0, 32'h0);
        queue_beat(OP_ILLEGAL, 32'h0000_0001, 3'd0, 32'hFFFF_FFFF);
        queue_beat(OP_ILLEGAL, 32'h0000_0001, 3'd7, 32'h0);
        queue_beat(OP_SAVE,    32'h0000_0000, 3'd7, 32'hFFFF_FFFF);
        queue_beat(OP_DELETE,  32'h0000_0001, 3'd0, 32'h0);
        queue_beat(OP_FIND,    32'h0000_0001, 3'd0, 32'h0);
        queue_beat(OP_DELETE,  32'h0000_0001, 3'd4, 32'h0);   // entry 0 freed
        queue_beat(OP_FIND,    32'h0000_0001, 3'd4, 32'h0);
        queue_beat(OP_SAVE,    32'h8000_0000, 3'd2, 32'h5A5A_5A5A); // reuses entry 0
        queue_beat(OP_FIND,    32'h8000_0000, 3'd2, 32'h0);
        queue_beat(OP_DELETE,  32'hFFFF_FFFF, 3'd4, 32'h0);   // entry 1 freed
        queue_beat(OP_SAVE,    32'h7FFF_FFFF, 3'd1, 32'hA5A5_A5A5);

        // random traffic over a small id pool, sender 16 / receiver 49
        id_pool.push_back(32'h0000_0001);
        id_pool.push_back(32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++)
            id_pool.push_back(fresh_id());
        for (int r = 0; r < 20; r++)
        begin
            push_traffic(12);
            if (r % 3 == 0)
                push_churn();
        end
        wait_drained();

        // fill the table past its end, sender 49 / receiver 16
        send_idle_pct <= 49;
        recv_idle_pct <= 16;
        for (int i = 0; i < NUM_ENTRIES + 6; i++)
        begin
            k = fresh_id();
            fill_ids.push_back(k);
            fill_ctx.push_back(CTX_W'($urandom_range(NUM_SLOTS - 1)));
            queue_beat(OP_SAVE, k, fill_ctx[i], $urandom);
            if (i % 8 == 0)
                queue_beat(OP_FIND, id_pool[$urandom_range(id_pool.size() - 1)],
                           CTX_W'($urandom_range(NUM_SLOTS - 1)), $urandom);
        end
        // full table: free an entry, refill it, spill into overflow
        for (int r = 0; r < 8; r++)
        begin
            j = $urandom_range(NUM_ENTRIES * 3 / 4);
            queue_beat(OP_DELETE, fill_ids[j], fill_ctx[j], $urandom);
            queue_beat(OP_FIND, fill_ids[j], fill_ctx[j], $urandom);
            k = fresh_id();
            queue_beat(OP_SAVE, k, CTX_W'($urandom_range(NUM_SLOTS - 1)), $urandom);
            queue_beat(OP_FIND, k, CTX_W'($urandom_range(NUM_SLOTS - 1)), $urandom);
            k = fresh_id();
            queue_beat(OP_SAVE, k, 3'd0, $urandom);
            queue_beat(OP_FIND, k, 3'd0, $urandom);
        end
        wait_drained();

        // no idling; mix in ids from the full table, one long receiver hold
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        for (int i = 0; i < 20; i++)
            id_pool.push_back(fill_ids[$urandom_range(NUM_ENTRIES * 3 / 4)]);
        c_base = beats_accepted;
        for (int r = 0; r < 25; r++)
        begin
            push_traffic(12);
            if (r % 4 == 0)
                push_churn();
        end
        while (beats_accepted < c_base + 40)
            @(posedge clk);
        hold_trigger <= hold_trigger + 1;
        wait_drained();

        // let any stray beat show up before the verdict
        repeat (DRAIN_WAIT) @(posedge clk);

        if (awaited_rsp.size() != 0)
        begin
            $error("responses: expected 0 outstanding, got %0d", awaited_rsp.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
